[src/dra_pkg.sv]
// Package: shared types and constants for the damage rectangle accumulator
`default_nettype none
package dra_pkg;
   localparam int MaxRects  = 8;
   localparam int SlotW     = $clog2(MaxRects);
   localparam int CntW      = $clog2(MaxRects + 1);
   localparam int QDepth    = 2;
   localparam logic [12:0] SurfLimit = 13'd4096;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_ENABLE = 2'd2;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_FULL   = 2'd1,
      ACT_FINISH = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef struct packed {
      logic [12:0] l;
      logic [12:0] t;
      logic [12:0] r;
      logic [12:0] b;
   } box_type;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_FULL   = 2'd1,
      CMD_FINISH = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         trk;
      box_type      box;
      logic         empty;
      logic [12:0]  w;
      logic [12:0]  h;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_INSERT, ST_GROW_RD, ST_GROW_MUL, ST_GROW_CMP,
      ST_MERGE, ST_SUM_RD, ST_SUM_MUL, ST_SUM_ACC, ST_DECIDE, ST_EMIT_RD,
      ST_EMIT_WAIT, ST_EMIT
   } state_type;
endpackage
`default_nettype wire

[src/dra_front.sv]
// Front end: accepts items, clamps bounds, queues commands
`default_nettype none
module dra_front
   import dra_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic signed [15:0] req_rect_left,
   input  wire logic signed [15:0] req_rect_top,
   input  wire logic signed [15:0] req_rect_right,
   input  wire logic signed [15:0] req_rect_bottom,
   input  wire logic [12:0] sw,
   input  wire logic [12:0] sh,
   input  wire logic        en,
   output logic             cmd_valid,
   input  wire logic        cmd_ready,
   output cmd_type          cmd
);
   cmd_type q_ff [QDepth];
   logic [0:0] wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] n_ff, n_in;
   logic signed [16:0] w, h, l, t, r, b;
   cmd_type c;
   logic push, pop;

   assign req_ready = (n_ff != 2'(QDepth));
   assign push = req_valid && req_ready && (req_action != ACT_NONE);
   assign pop  = cmd_valid && cmd_ready;
   assign cmd_valid = (n_ff != 2'd0);
   assign cmd = q_ff[rp_ff];

   always_comb begin
      w = (sw > SurfLimit) ? 17'sd4096 : signed'({4'd0, sw});
      h = (sh > SurfLimit) ? 17'sd4096 : signed'({4'd0, sh});
      l = 17'(req_rect_left);
      t = 17'(req_rect_top);
      r = 17'(req_rect_right);
      b = 17'(req_rect_bottom);
      if (l < 0) l = '0;
      if (t < 0) t = '0;
      if (r > w) r = w;
      if (b > h) b = h;
      c.kind  = cmd_kind_type'(req_action);
      c.trk   = en;
      c.empty = (r <= l) || (b <= t);
      c.box.l = l[12:0];
      c.box.t = t[12:0];
      c.box.r = r[12:0];
      c.box.b = b[12:0];
      c.w = w[12:0];
      c.h = h[12:0];
      wp_in = push ? wp_ff + 1'b1 : wp_ff;
      rp_in = pop ? rp_ff + 1'b1 : rp_ff;
      n_in  = n_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         n_ff  <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         n_ff  <= n_in;
      end
      if (push) q_ff[wp_ff] <= c;
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) n_ff <= 2'(QDepth))
      else $error("queue overflow");
   a_full: assert property (@(posedge clock) disable iff (reset)
      (n_ff == 2'(QDepth)) |-> !req_ready) else $error("ready while full");
   a_emp: assert property (@(posedge clock) disable iff (reset)
      (n_ff == 2'd0) |-> !cmd_valid) else $error("valid while empty");
endmodule
`default_nettype wire

[src/dra_back.sv]
// Back end: rectangle store, merge logic, frame result sequencer
`default_nettype none
module dra_back
   import dra_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   output logic             cmd_ready,
   input  wire cmd_type     cmd,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [11:0]      rsp_out_x,
   output logic [11:0]      rsp_out_y,
   output logic [12:0]      rsp_out_w,
   output logic [12:0]      rsp_out_h,
   output logic             rsp_full_repaint,
   output logic             rsp_unchanged,
   output logic             rsp_last_rect
);
   box_type mem [MaxRects];
   box_type rd_ff;
   state_type st_ff, st_in;
   cmd_type c_ff, c_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [SlotW-1:0] idx_ff, idx_in, best_ff, best_in, ra;
   logic chg_ff, chg_in, full_ff, full_in;
   logic [25:0] ga_ff, gb_ff, prod_ff;
   logic [26:0] bg_ff, bg_in;
   logic [28:0] sum_ff, sum_in;
   logic [36:0] lim_prod, sum_x10;
   logic [12:0] w_ff, h_ff;
   box_type u, ou;
   logic [12:0] ul, ut, ur, ub, il, it, ir, ib;
   logic ov, we, last_idx;
   box_type wd;
   logic [SlotW-1:0] wa;
   logic [11:0] ox_in, oy_in;
   logic [12:0] ow_in, oh_in;
   logic of_in, ou_in, ol_in, ld;
   logic [11:0] ox_ff, oy_ff;
   logic [12:0] ow_ff, oh_ff;
   logic of_ff, oun_ff, ol_ff, ov_ff, ov_in;
   logic [26:0] g;

   assign rsp_valid = ov_ff;
   assign rsp_out_x = ox_ff;
   assign rsp_out_y = oy_ff;
   assign rsp_out_w = ow_ff;
   assign rsp_out_h = oh_ff;
   assign rsp_full_repaint = of_ff;
   assign rsp_unchanged = oun_ff;
   assign rsp_last_rect = ol_ff;

   always_comb begin
      ul = (rd_ff.l < c_ff.box.l) ? rd_ff.l : c_ff.box.l;
      ut = (rd_ff.t < c_ff.box.t) ? rd_ff.t : c_ff.box.t;
      ur = (rd_ff.r > c_ff.box.r) ? rd_ff.r : c_ff.box.r;
      ub = (rd_ff.b > c_ff.box.b) ? rd_ff.b : c_ff.box.b;
      u = '{ul, ut, ur, ub};
      il = (rd_ff.l > c_ff.box.l) ? rd_ff.l : c_ff.box.l;
      it = (rd_ff.t > c_ff.box.t) ? rd_ff.t : c_ff.box.t;
      ir = (rd_ff.r < c_ff.box.r) ? rd_ff.r : c_ff.box.r;
      ib = (rd_ff.b < c_ff.box.b) ? rd_ff.b : c_ff.box.b;
      ov = (il < ir) && (it < ib);
      ou = u;
      // sum > floor(6*w*h/10) is the same as 10*sum > 6*w*h
      lim_prod = 37'(26'(w_ff) * 26'(h_ff)) * 37'd6;
      sum_x10 = 37'(sum_ff) * 37'd10;
      g = 27'(prod_ff) - 27'(ga_ff);
      last_idx = (32'(idx_ff) + 32'd1 == 32'(cnt_ff));
   end

   always_comb begin
      st_in = st_ff; c_in = c_ff; cnt_in = cnt_ff; idx_in = idx_ff; best_in = best_ff;
      chg_in = chg_ff; full_in = full_ff; bg_in = bg_ff; sum_in = sum_ff;
      we = 1'b0; wa = idx_ff; wd = ou; ra = idx_ff;
      cmd_ready = 1'b0; ld = 1'b0;
      ox_in = '0; oy_in = '0; ow_in = '0; oh_in = '0; of_in = 1'b0; ou_in = 1'b0; ol_in = 1'b0;
      ov_in = ov_ff && !rsp_ready;
      unique case (st_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            idx_in = '0; ra = '0;
            if (cmd_valid) begin
               c_in = cmd;
               unique case (cmd.kind)
                  CMD_FULL: begin chg_in = 1'b1; full_in = 1'b1; end
                  CMD_ADD: begin
                     chg_in = 1'b1;
                     if (!cmd.trk) full_in = 1'b1;
                     else if (!full_ff && !cmd.empty)
                        st_in = (cnt_ff == '0) ? ST_INSERT : ST_SCAN;
                  end
                  CMD_FINISH: begin
                     sum_in = '0;
                     if (!chg_ff && !full_ff) st_in = ST_DECIDE;
                     else if (full_ff || cnt_ff == '0) begin
                        full_in = 1'b1; st_in = ST_DECIDE;
                     end
                     else st_in = ST_SUM_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (ov) begin
               we = 1'b1; st_in = ST_IDLE;
            end else if (last_idx) begin
               if (32'(cnt_ff) < MaxRects) st_in = ST_INSERT;
               else begin idx_in = '0; ra = '0; bg_in = 27'h7ffffff; st_in = ST_GROW_RD; end
            end else begin
               idx_in = idx_ff + SlotW'(1); ra = idx_ff + SlotW'(1);
            end
         end
         ST_INSERT: begin
            we = 1'b1; wa = SlotW'(cnt_ff); wd = c_ff.box;
            cnt_in = cnt_ff + CntW'(1); st_in = ST_IDLE;
         end
         ST_GROW_RD: st_in = ST_GROW_MUL;
         ST_GROW_MUL: st_in = ST_GROW_CMP;
         ST_GROW_CMP: begin
            if (g < bg_ff) begin bg_in = g; best_in = idx_ff; end
            if (32'(idx_ff) == MaxRects - 1) begin ra = (g < bg_ff) ? idx_ff : best_ff;
               st_in = ST_MERGE; end
            else begin
               idx_in = idx_ff + SlotW'(1); ra = idx_ff + SlotW'(1); st_in = ST_GROW_RD;
            end
         end
         ST_MERGE: begin
            we = 1'b1; wa = best_ff; st_in = ST_IDLE;
         end
         ST_SUM_RD: st_in = ST_SUM_MUL;
         ST_SUM_MUL: st_in = ST_SUM_ACC;
         ST_SUM_ACC: begin
            sum_in = sum_ff + 29'(prod_ff);
            if (last_idx) st_in = ST_DECIDE;
            else begin
               idx_in = idx_ff + SlotW'(1); ra = idx_ff + SlotW'(1); st_in = ST_SUM_RD;
            end
         end
         ST_DECIDE: begin
            if (!ov_ff || rsp_ready) begin
               if (!chg_ff && !full_ff) begin
                  ld = 1'b1; ou_in = 1'b1; ol_in = 1'b1; st_in = ST_IDLE;
               end else if (full_ff || sum_x10 > lim_prod) begin
                  ld = 1'b1; of_in = 1'b1; ol_in = 1'b1;
                  ow_in = w_ff; oh_in = h_ff; st_in = ST_IDLE;
               end else begin
                  idx_in = '0; ra = '0; st_in = ST_EMIT_RD;
               end
               if (st_in == ST_IDLE) begin
                  cnt_in = '0; chg_in = 1'b0; full_in = 1'b0;
               end
            end
         end
         ST_EMIT_RD: st_in = ST_EMIT;
         ST_EMIT_WAIT: st_in = ST_EMIT;
         ST_EMIT: begin
            if (!ov_ff || rsp_ready) begin
               ld = 1'b1;
               ox_in = rd_ff.l[11:0]; oy_in = rd_ff.t[11:0];
               ow_in = rd_ff.r - rd_ff.l; oh_in = rd_ff.b - rd_ff.t;
               ol_in = last_idx;
               if (last_idx) begin
                  st_in = ST_IDLE; cnt_in = '0; chg_in = 1'b0; full_in = 1'b0;
               end else begin
                  idx_in = idx_ff + SlotW'(1); ra = idx_ff + SlotW'(1); st_in = ST_EMIT_WAIT;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (ld) ov_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; cnt_ff <= '0; chg_ff <= 1'b0; full_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; chg_ff <= chg_in; full_ff <= full_in; ov_ff <= ov_in;
      end
      c_ff <= c_in; idx_ff <= idx_in; best_ff <= best_in; bg_ff <= bg_in; sum_ff <= sum_in;
      if (st_ff == ST_IDLE && cmd_valid) begin w_ff <= cmd.w; h_ff <= cmd.h; end
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
      ga_ff <= 26'(rd_ff.r - rd_ff.l) * 26'(rd_ff.b - rd_ff.t);
      gb_ff <= 26'(u.r - u.l) * 26'(u.b - u.t);
      prod_ff <= (st_ff == ST_SUM_MUL) ? ga_ff : gb_ff;
      if (ld) begin
         ox_ff <= ox_in; oy_ff <= oy_in; ow_ff <= ow_in; oh_ff <= oh_in;
         of_ff <= of_in; oun_ff <= ou_in; ol_ff <= ol_in;
      end
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) 32'(cnt_ff) <= MaxRects)
      else $error("count overflow");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !rsp_ready) |=> ov_ff) else $error("result dropped");
   a_clr: assert property (@(posedge clock) disable iff (reset)
      (ld && ol_in) |=> (cnt_ff == '0 && !chg_ff)) else $error("frame not cleared");
endmodule
`default_nettype wire

[src/damage_rect_accumulator_unit.sv]
// Top level: damage rectangle accumulator
// Throughput: sequential; the back end serves one command at a time (slot walks over memory).
// Input side takes items through a two-entry queue; results leave one at a time through a held output register.
// Reset is synchronous; it clears counts, flags and config to 1920, 1080, enabled.
`default_nettype none
module damage_rect_accumulator_unit
   import dra_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic signed [15:0] req_rect_left,
   input  wire logic signed [15:0] req_rect_top,
   input  wire logic signed [15:0] req_rect_right,
   input  wire logic signed [15:0] req_rect_bottom,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [11:0]      rsp_out_x,
   output logic [11:0]      rsp_out_y,
   output logic [12:0]      rsp_out_w,
   output logic [12:0]      rsp_out_h,
   output logic             rsp_full_repaint,
   output logic             rsp_unchanged,
   output logic             rsp_last_rect,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [12:0] csr_wdata
);
   logic [12:0] sw_ff, sh_ff;
   logic en_ff;
   logic cmd_valid, cmd_ready;
   cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= 13'd1920; sh_ff <= 13'd1080; en_ff <= 1'b1;
      end else if (csr_we) begin
         if (csr_index == REG_WIDTH) sw_ff <= csr_wdata;
         if (csr_index == REG_HEIGHT) sh_ff <= csr_wdata;
         if (csr_index == REG_ENABLE) en_ff <= csr_wdata[0];
      end
   end

   dra_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_action, .req_rect_left, .req_rect_top,
      .req_rect_right, .req_rect_bottom, .sw(sw_ff), .sh(sh_ff), .en(en_ff),
      .cmd_valid, .cmd_ready, .cmd
   );

   dra_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd, .rsp_valid, .rsp_ready,
      .rsp_out_x, .rsp_out_y, .rsp_out_w, .rsp_out_h, .rsp_full_repaint,
      .rsp_unchanged, .rsp_last_rect
   );
endmodule
`default_nettype wire

[test/damage_rect_accumulator_unit_tb.sv]
// Testbench for damage_rect_accumulator_unit: random and directed frames against a predictor
`timescale 1ns / 100ps
module damage_rect_accumulator_unit_tb;
   import dra_pkg::*;

   typedef struct {
      logic [1:0]  action;
      logic [15:0] l, t, r, b;
   } damage_req_type;

   typedef struct {
      logic [11:0] x, y;
      logic [12:0] w, h;
      logic        full, unch, last;
   } damage_rsp_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0, csr_we = 0;
   logic [1:0] req_action = ACT_NONE, csr_index = 0;
   logic signed [15:0] req_rect_left = 0, req_rect_top = 0, req_rect_right = 0,
      req_rect_bottom = 0;
   logic [12:0] csr_wdata = 0;
   logic req_ready, rsp_valid, rsp_full_repaint, rsp_unchanged, rsp_last_rect;
   logic [11:0] rsp_out_x, rsp_out_y;
   logic [12:0] rsp_out_w, rsp_out_h;

   damage_rect_accumulator_unit dut (.*);

   damage_req_type pending_reqs[$];
   damage_rsp_type expected_rects[$];
   int send_idle_pct = 0, recv_stall_pct = 0, mismatches = 0;
   int hold_left = 0;
   bit hold_go = 0;

   // predictor state
   int surf_w = 1920, surf_h = 1080;
   bit track_en = 1;
   int box_l[MaxRects], box_t[MaxRects], box_r[MaxRects], box_b[MaxRects];
   int box_cnt = 0;
   bit frame_changed = 0, frame_full = 0;

   always #5 clock = ~clock;

   function automatic int clamp_dim(int v);
      return v > 4096 ? 4096 : v;
   endfunction

   function automatic longint area_of(int l, int t, int r, int b);
      return longint'(r - l) * longint'(b - t);
   endfunction

   function automatic void merge_into(int i, int l, int t, int r, int b);
      if (l < box_l[i]) box_l[i] = l;
      if (t < box_t[i]) box_t[i] = t;
      if (r > box_r[i]) box_r[i] = r;
      if (b > box_b[i]) box_b[i] = b;
   endfunction

   function automatic void accumulate_box(int l, int t, int r, int b);
      int w, h, best;
      longint least_gain, g;
      w = clamp_dim(surf_w);
      h = clamp_dim(surf_h);
      best = 0;
      least_gain = 64'h7fffffff;
      if (l < 0) l = 0;
      if (t < 0) t = 0;
      if (r > w) r = w;
      if (b > h) b = h;
      if (r <= l || b <= t) return;
      for (int i = 0; i < box_cnt; i++) begin
         if ((l > box_l[i] ? l : box_l[i]) < (r < box_r[i] ? r : box_r[i]) &&
             (t > box_t[i] ? t : box_t[i]) < (b < box_b[i] ? b : box_b[i])) begin
            merge_into(i, l, t, r, b);
            return;
         end
      end
      if (box_cnt < MaxRects) begin
         box_l[box_cnt] = l; box_t[box_cnt] = t; box_r[box_cnt] = r; box_b[box_cnt] = b;
         box_cnt++;
         return;
      end
      for (int i = 0; i < MaxRects; i++) begin
         g = area_of(l < box_l[i] ? l : box_l[i], t < box_t[i] ? t : box_t[i],
                     r > box_r[i] ? r : box_r[i], b > box_b[i] ? b : box_b[i])
             - area_of(box_l[i], box_t[i], box_r[i], box_b[i]);
         if (g < least_gain) begin
            least_gain = g;
            best = i;
         end
      end
      merge_into(best, l, t, r, b);
   endfunction

   function automatic void predict_damage(damage_req_type q);
      damage_rsp_type o;
      int w, h;
      bit full;
      longint area;
      if (q.action == ACT_ADD) begin
         frame_changed = 1;
         if (!track_en) frame_full = 1;
         else if (!frame_full)
            accumulate_box(int'($signed(q.l)), int'($signed(q.t)),
                           int'($signed(q.r)), int'($signed(q.b)));
         return;
      end
      if (q.action == ACT_FULL) begin
         frame_changed = 1;
         frame_full = 1;
         return;
      end
      if (q.action != ACT_FINISH) return;
      w = clamp_dim(surf_w);
      h = clamp_dim(surf_h);
      full = frame_full;
      o = '{default: 0};
      if (!full && !frame_changed) begin
         o.unch = 1; o.last = 1;
         expected_rects.push_back(o);
      end else begin
         if (!full) begin
            area = 0;
            for (int i = 0; i < box_cnt; i++)
               area += area_of(box_l[i], box_t[i], box_r[i], box_b[i]);
            if (box_cnt == 0 || area > (longint'(w) * h * 6) / 10) full = 1;
         end
         if (full) begin
            o.w = w; o.h = h; o.full = 1; o.last = 1;
            expected_rects.push_back(o);
         end else
            for (int i = 0; i < box_cnt; i++) begin
               o.x = box_l[i]; o.y = box_t[i];
               o.w = box_r[i] - box_l[i]; o.h = box_b[i] - box_t[i];
               o.last = (i + 1 == box_cnt);
               expected_rects.push_back(o);
            end
      end
      box_cnt = 0;
      frame_changed = 0;
      frame_full = 0;
   endfunction

   task automatic send_item(logic [1:0] a, int l, int t, int r, int b);
      damage_req_type q;
      q.action = a; q.l = l; q.t = t; q.r = r; q.b = b;
      predict_damage(q);
      pending_reqs.push_back(q);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [12:0] v);
      @(posedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         REG_WIDTH:  surf_w = v;
         REG_HEIGHT: surf_h = v;
         default:    track_en = v[0];
      endcase
   endtask

   task automatic drain;
      wait (pending_reqs.size() == 0 && !req_valid && expected_rects.size() == 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic setup_phase(int w, int h, bit en, int idle, int stall);
      drain();
      write_csr(REG_WIDTH, w);
      write_csr(REG_HEIGHT, h);
      write_csr(REG_ENABLE, en);
      send_idle_pct = idle;
      recv_stall_pct = stall;
   endtask

   task automatic random_frames(int n_items);
      int sent, k, w, h, x, y, sel;
      sent = 0;
      w = clamp_dim(surf_w) < 1 ? 1 : clamp_dim(surf_w);
      h = clamp_dim(surf_h) < 1 ? 1 : clamp_dim(surf_h);
      while (sent < n_items) begin
         k = $urandom_range(0, 12);
         repeat (k) begin
            sel = $urandom_range(99);
            x = $urandom_range(0, w);
            y = $urandom_range(0, h);
            if (sel < 80)
               send_item(ACT_ADD, x - $urandom_range(0, 4), y - $urandom_range(0, 4),
                         x + $urandom_range(0, w / 6 + 2), y + $urandom_range(0, h / 6 + 2));
            else if (sel < 90)
               send_item(ACT_ADD, $urandom, $urandom, $urandom, $urandom);
            else if (sel < 95)
               send_item(ACT_FULL, $urandom, $urandom, $urandom, $urandom);
            else
               send_item(ACT_NONE, $urandom, $urandom, $urandom, $urandom);
         end
         send_item(ACT_FINISH, $urandom, $urandom, $urandom, $urandom);
         sent += k + 1;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_ready) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            damage_req_type q;
            q = pending_reqs.pop_front();
            req_action <= q.action;
            req_rect_left <= q.l; req_rect_top <= q.t;
            req_rect_right <= q.r; req_rect_bottom <= q.b;
            req_valid <= 1;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_go) hold_left <= 400;
      else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_rects.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result transfer x=%0d y=%0d",
                                              rsp_out_x, rsp_out_y);
            end else begin
               damage_rsp_type e;
               e = expected_rects.pop_front();
               if (rsp_out_x !== e.x || rsp_out_y !== e.y || rsp_out_w !== e.w ||
                   rsp_out_h !== e.h || rsp_full_repaint !== e.full ||
                   rsp_unchanged !== e.unch || rsp_last_rect !== e.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch exp x=%0d y=%0d w=%0d h=%0d f=%0d u=%0d l=%0d",
                               " got x=%0d y=%0d w=%0d h=%0d f=%0d u=%0d l=%0d"},
                        e.x, e.y, e.w, e.h, e.full, e.unch, e.last, rsp_out_x, rsp_out_y,
                        rsp_out_w, rsp_out_h, rsp_full_repaint, rsp_unchanged,
                        rsp_last_rect);
               end
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: clamping, empty add, merges, least growth, force full, no change
      send_item(ACT_FINISH, 0, 0, 0, 0);
      send_item(ACT_ADD, -32768, -32768, 32767, 32767);
      send_item(ACT_FINISH, 0, 0, 0, 0);
      send_item(ACT_ADD, 50, 50, 50, 60);
      send_item(ACT_FINISH, 0, 0, 0, 0);
      send_item(ACT_ADD, 10, 10, 20, 20);
      send_item(ACT_ADD, 15, 15, 30, 30);
      send_item(ACT_ADD, 30, 30, 40, 40);
      for (int i = 0; i < 7; i++) send_item(ACT_ADD, 100 * i + 200, 500, 100 * i + 210, 510);
      send_item(ACT_ADD, 1900, 1070, 1919, 1079);
      send_item(ACT_NONE, -1, -1, -1, -1);
      send_item(ACT_FINISH, 0, 0, 0, 0);
      send_item(ACT_FULL, 0, 0, 0, 0);
      send_item(ACT_ADD, 1, 1, 5, 5);
      send_item(ACT_FINISH, 0, 0, 0, 0);
      send_item(ACT_ADD, 5, 5, 9, 9);
      send_item(ACT_FINISH, 0, 0, 0, 0);
      setup_phase(1920, 1080, 1, 74, 0);
      random_frames(50);
      setup_phase(4096, 4096, 1, 0, 74);
      hold_go <= 1;
      @(posedge clock);
      hold_go <= 0;
      random_frames(60);
      setup_phase(1, 1, 1, 38, 38);
      random_frames(40);
      setup_phase(8191, 8191, 1, 0, 0);
      random_frames(50);
      setup_phase(640, 480, 0, 74, 0);
      random_frames(35);
      setup_phase(0, 37, 1, 0, 74);
      random_frames(35);
      setup_phase(100, 60, 1, 38, 38);
      random_frames(55);
      setup_phase(1920, 1080, 1, 0, 0);
      random_frames(45);
      drain();
      if (mismatches == 0 && expected_rects.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
